[rtl/core/msfe_pkg.sv]
// Package for the mono stripe frame buffer engine.
// Holds the request/response beat types and the opcode and status codes.
// No dependencies.
package msfe_pkg;

   typedef enum logic [1:0] {
      OP_FILL  = 2'd0,
      OP_OPEN  = 2'd1,
      OP_DATA  = 2'd2,
      OP_FLUSH = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_NO_RECT = 2'd2,
      ST_SPARE   = 2'd3
   } status_type;

   localparam logic [7:0] CMD_Y = 8'h40;
   localparam logic [7:0] CMD_X = 8'h80;
   localparam int STRIPE_ROWS = 8;

   typedef struct packed {
      logic [1:0] opcode;
      logic       colour_flag;
      logic [6:0] x_first;
      logic [6:0] x_last;
      logic [5:0] y_first;
      logic [5:0] y_last;
      logic [7:0] pixel_bits;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_is_command;
      logic       out_valid;
      logic       out_last;
      logic [1:0] status;
   } rsp_type;

   // Classified item passed from the front end to the back end.
   typedef struct packed {
      req_type    req;
      logic       range_ok;
   } work_type;

endpackage

[rtl/core/msfe_front.sv]
// Front end: accepts request beats, checks rectangle range, and queues them.
// Depends on msfe_pkg.
module msfe_front #(
   parameter int COLUMNS = 84,
   parameter int ROWS = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  msfe_pkg::req_type req_data,
   output logic              work_valid,
   input  logic              work_take,
   output msfe_pkg::work_type work_data
);

   msfe_pkg::work_type q_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ff, rd_in, wr_ff, wr_in;
   logic       push_ok, take_ok;
   msfe_pkg::work_type item;

   assign req_full = (count_ff == 2'd2);
   assign push_ok = req_push && !req_full;
   assign work_valid = (count_ff != 2'd0);
   assign take_ok = work_take && work_valid;
   assign work_data = q_ff[rd_ff];

   always_comb begin
      item.req = req_data;
      item.range_ok = (req_data.x_first <= req_data.x_last)
         && ({25'd0, req_data.x_last} < COLUMNS)
         && (req_data.y_first <= req_data.y_last)
         && ({26'd0, req_data.y_last} < ROWS);
      count_in = count_ff + {1'b0, push_ok} - {1'b0, take_ok};
      wr_in = wr_ff ^ push_ok;
      rd_in = rd_ff ^ take_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         rd_ff <= rd_in;
         wr_ff <= wr_in;
      end
      if (push_ok) begin
         q_ff[wr_ff] <= item;
      end
   end

endmodule

[rtl/core/msfe_back.sv]
// Back end: frame store, fill and mono painting sequencer, flush and dirty tracking.
// Depends on msfe_pkg.
module msfe_back #(
   parameter int COLUMNS = 84,
   parameter int STRIPE_COUNT = 6
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               work_valid,
   output logic               work_take,
   input  msfe_pkg::work_type work_data,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output msfe_pkg::rsp_type  rsp_data
);

   localparam int DEPTH = COLUMNS * STRIPE_COUNT;
   localparam int AW = $clog2(DEPTH);
   localparam int SW = (STRIPE_COUNT > 1) ? $clog2(STRIPE_COUNT + 1) : 1;
   localparam int FW = $clog2(DEPTH + 3);
   localparam int CW = 14;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FILL_RD, S_FILL_WR, S_MONO_RD, S_MONO_WR, S_FLUSH_RD, S_OUT
   } state_type;

   logic [7:0] mem [DEPTH];
   logic [7:0] rdata_ff;

   state_type state_ff;
   logic [AW-1:0] addr_ff;
   logic [6:0] x_ff, x_first_ff, x_last_ff;
   logic [2:0] s_ff, s_last_ff;
   logic [2:0] x_first_stripe_ff;
   logic [7:0] mask_first_ff, mask_last_ff;
   logic       colour_ff;
   logic [6:0] rx0_ff, rx1_ff;
   logic [5:0] ry0_ff, ry1_ff;
   logic [5:0] my_ff;
   logic [6:0] mx_ff;
   logic [CW-1:0] cursor_ff;
   logic [CW-1:0] area_ff;
   logic       open_ff, invert_ff;
   logic [7:0] bits_ff;
   logic [3:0] k_ff;
   logic [SW-1:0] top_ff, bottom_ff;
   logic [FW-1:0] fpos_ff;
   logic       flast_ff;
   msfe_pkg::rsp_type out_ff;
   logic       full_ff;

   logic [AW-1:0] idx_base;
   logic [7:0] fill_mask;
   logic [7:0] mono_bit;
   logic       mono_on;
   logic [SW-1:0] cnt_stripes;
   logic [FW-1:0] count, off;
   msfe_pkg::req_type r;
   msfe_pkg::rsp_type beat_in;

   assign r = work_data.req;
   assign rsp_empty = !full_ff;
   assign rsp_data = out_ff;
   assign work_take = (state_ff == S_IDLE) && work_valid && !full_ff;

   always_comb begin
      fill_mask = 8'hFF;
      if (s_ff == x_first_stripe_ff) fill_mask = fill_mask & mask_first_ff;
      if (s_ff == s_last_ff) fill_mask = fill_mask & mask_last_ff;
      idx_base = AW'(s_ff * COLUMNS) + AW'(x_ff);
      mono_on = bits_ff[7] ^ invert_ff;
      mono_bit = 8'd1 << my_ff[2:0];
      cnt_stripes = bottom_ff - top_ff + SW'(1);
      count = FW'(COLUMNS) * FW'(cnt_stripes);
      off = fpos_ff - FW'(2);
      if (off >= count) off = count - FW'(1);
   end

   always_comb begin
      beat_in = '0;
      case (r.opcode)
         msfe_pkg::OP_FILL: begin
            if (!work_data.range_ok) beat_in.status = msfe_pkg::ST_RANGE;
         end
         msfe_pkg::OP_OPEN: begin
            if (!work_data.range_ok) beat_in.status = msfe_pkg::ST_RANGE;
         end
         msfe_pkg::OP_DATA: begin
            if (!open_ff) beat_in.status = msfe_pkg::ST_NO_RECT;
         end
         default: begin
            if (top_ff <= bottom_ff && bottom_ff < SW'(STRIPE_COUNT)) begin
               beat_in.out_valid = 1'b1;
               if (fpos_ff == FW'(0)) begin
                  beat_in.out_byte = msfe_pkg::CMD_Y | 8'(top_ff);
                  beat_in.out_is_command = 1'b1;
               end else if (fpos_ff == FW'(1)) begin
                  beat_in.out_byte = msfe_pkg::CMD_X;
                  beat_in.out_is_command = 1'b1;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff <= '0;
         open_ff <= 1'b0;
         invert_ff <= 1'b0;
         top_ff <= SW'(STRIPE_COUNT);
         bottom_ff <= '0;
         fpos_ff <= '0;
         full_ff <= 1'b0;
         cursor_ff <= '0;
         rx0_ff <= '0;
         rx1_ff <= '0;
         ry0_ff <= '0;
         ry1_ff <= '0;
      end else begin
         if (rsp_pop && full_ff) full_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               mem[addr_ff] <= 8'd0;
               if (addr_ff == AW'(DEPTH - 1)) state_ff <= S_IDLE;
               addr_ff <= addr_ff + AW'(1);
            end
            S_IDLE: begin
               if (work_take) begin
                  out_ff <= beat_in;
                  case (r.opcode)
                     msfe_pkg::OP_FILL: begin
                        if (!work_data.range_ok) begin
                           state_ff <= S_OUT;
                        end else begin
                           x_ff <= r.x_first;
                           x_first_ff <= r.x_first;
                           x_last_ff <= r.x_last;
                           s_ff <= r.y_first[5:3];
                           x_first_stripe_ff <= r.y_first[5:3];
                           s_last_ff <= r.y_last[5:3];
                           mask_first_ff <= 8'hFF << r.y_first[2:0];
                           mask_last_ff <= 8'hFF >> (3'd7 - r.y_last[2:0]);
                           colour_ff <= r.colour_flag;
                           if (SW'(r.y_first[5:3]) < top_ff) top_ff <= SW'(r.y_first[5:3]);
                           if (SW'(r.y_last[5:3]) > bottom_ff) bottom_ff <= SW'(r.y_last[5:3]);
                           state_ff <= S_FILL_RD;
                        end
                     end
                     msfe_pkg::OP_OPEN: begin
                        if (!work_data.range_ok) begin
                           open_ff <= 1'b0;
                           invert_ff <= 1'b0;
                        end else begin
                           rx0_ff <= r.x_first;
                           rx1_ff <= r.x_last;
                           ry0_ff <= r.y_first;
                           ry1_ff <= r.y_last;
                           mx_ff <= r.x_first;
                           my_ff <= r.y_first;
                           cursor_ff <= '0;
                           area_ff <= (CW'(r.x_last) - CW'(r.x_first) + CW'(1))
                              * (CW'(r.y_last) - CW'(r.y_first) + CW'(1));
                           open_ff <= 1'b1;
                           invert_ff <= r.colour_flag;
                        end
                        state_ff <= S_OUT;
                     end
                     msfe_pkg::OP_DATA: begin
                        if (!open_ff) begin
                           state_ff <= S_OUT;
                        end else begin
                           bits_ff <= r.pixel_bits;
                           k_ff <= '0;
                           if (SW'(ry0_ff[5:3]) < top_ff) top_ff <= SW'(ry0_ff[5:3]);
                           if (SW'(ry1_ff[5:3]) > bottom_ff) bottom_ff <= SW'(ry1_ff[5:3]);
                           state_ff <= S_MONO_RD;
                        end
                     end
                     default: begin
                        if (top_ff <= bottom_ff && bottom_ff < SW'(STRIPE_COUNT)) begin
                           if (fpos_ff == FW'(0)) begin
                              fpos_ff <= FW'(1);
                              state_ff <= S_OUT;
                           end else if (fpos_ff == FW'(1)) begin
                              fpos_ff <= FW'(2);
                              state_ff <= S_OUT;
                           end else begin
                              addr_ff <= AW'(top_ff * COLUMNS) + AW'(off);
                              flast_ff <= (off + FW'(1) >= count);
                              if (off + FW'(1) >= count) begin
                                 fpos_ff <= '0;
                                 top_ff <= SW'(STRIPE_COUNT);
                                 bottom_ff <= '0;
                              end else begin
                                 fpos_ff <= fpos_ff + FW'(1);
                              end
                              state_ff <= S_FLUSH_RD;
                           end
                        end else begin
                           fpos_ff <= '0;
                           state_ff <= S_OUT;
                        end
                     end
                  endcase
               end
            end
            S_FILL_RD: begin
               rdata_ff <= mem[idx_base];
               addr_ff <= idx_base;
               state_ff <= S_FILL_WR;
            end
            S_FILL_WR: begin
               mem[addr_ff] <= colour_ff ? (rdata_ff | fill_mask) : (rdata_ff & ~fill_mask);
               if (s_ff == s_last_ff) begin
                  s_ff <= x_first_stripe_ff;
                  if (x_ff == x_last_ff) state_ff <= S_OUT;
                  else begin
                     x_ff <= x_ff + 7'd1;
                     state_ff <= S_FILL_RD;
                  end
               end else begin
                  s_ff <= s_ff + 3'd1;
                  state_ff <= S_FILL_RD;
               end
            end
            S_MONO_RD: begin
               if (k_ff == 4'd8 || cursor_ff >= area_ff) begin
                  if (cursor_ff >= area_ff) begin
                     open_ff <= 1'b0;
                     invert_ff <= 1'b0;
                  end
                  state_ff <= S_OUT;
               end else begin
                  addr_ff <= AW'(my_ff[5:3] * COLUMNS) + AW'(mx_ff);
                  rdata_ff <= mem[AW'(my_ff[5:3] * COLUMNS) + AW'(mx_ff)];
                  state_ff <= S_MONO_WR;
               end
            end
            S_MONO_WR: begin
               mem[addr_ff] <= mono_on ? (rdata_ff | mono_bit) : (rdata_ff & ~mono_bit);
               bits_ff <= {bits_ff[6:0], 1'b0};
               k_ff <= k_ff + 4'd1;
               cursor_ff <= cursor_ff + CW'(1);
               if (mx_ff == rx1_ff) begin
                  mx_ff <= rx0_ff;
                  my_ff <= my_ff + 6'd1;
               end else begin
                  mx_ff <= mx_ff + 7'd1;
               end
               state_ff <= S_MONO_RD;
            end
            S_FLUSH_RD: begin
               out_ff.out_byte <= mem[addr_ff];
               out_ff.out_last <= flast_ff;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               full_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

[rtl/core/mono_stripe_framebuffer_engine_unit.sv]
// Top level of the mono stripe frame buffer engine: front end queue and back end.
// Depends on msfe_pkg, msfe_front and msfe_back.
//
//   channel   direction  handshake          beat
//   req_      in         req_push/req_full  msfe_pkg::req_type
//   rsp_      out        rsp_pop/rsp_empty  msfe_pkg::rsp_type
//
// One item at a time runs in the back end through its single-port frame store.
// Open, flush commands and errors go straight to output; a flush data byte reads
// the store, a mono byte reads and writes it per pixel painted, a fill per column
// per stripe touched. After reset a clearing pass zeroes all COLUMNS*STRIPE_COUNT
// bytes; requests wait in the front end queue. Pending responses stall the back end.
module mono_stripe_framebuffer_engine_unit #(
   parameter int COLUMNS = 84,
   parameter int STRIPE_COUNT = 6
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  msfe_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output msfe_pkg::rsp_type rsp_data
);

   logic               work_valid;
   logic               work_take;
   msfe_pkg::work_type work_data;

   msfe_front #(
      .COLUMNS(COLUMNS),
      .ROWS(STRIPE_COUNT * msfe_pkg::STRIPE_ROWS)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .work_valid(work_valid), .work_take(work_take), .work_data(work_data)
   );

   msfe_back #(
      .COLUMNS(COLUMNS),
      .STRIPE_COUNT(STRIPE_COUNT)
   ) u_back (
      .clock(clock), .reset(reset),
      .work_valid(work_valid), .work_take(work_take), .work_data(work_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

endmodule

[test/tb_top.sv]
// Self-checking testbench for mono_stripe_framebuffer_engine_unit: directed table, then random
// fills, mono rectangles and flushes, each response compared with an in-bench frame predictor.
// Depends on msfe_pkg and the engine RTL.
`timescale 1ns / 1ps

module tb_top;

   localparam int COLS = 84;
   localparam int STRIPES = 6;
   localparam int ITEM_TARGET = 1900;

   typedef struct {
      msfe_pkg::req_type req;
      bit                fixed;
      msfe_pkg::rsp_type rsp;
   } table_row_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_push;
   logic              req_full;
   msfe_pkg::req_type req_data;
   logic              rsp_empty;
   logic              rsp_pop;
   msfe_pkg::rsp_type rsp_data;

   msfe_pkg::rsp_type expected_beats[$];
   table_row_type     directed[$];
   bit                failed = 0;
   int                sent_count = 0;

   logic [7:0] shadow_frame[0:COLS*STRIPES-1];
   int         damage_top, damage_bottom;
   int         win_x0, win_x1, win_y0, win_y1;
   int         pixel_cursor, flush_step;
   bit         window_open, window_invert;

   mono_stripe_framebuffer_engine_unit uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic bit bounds_ok(int x0, int x1, int y0, int y1);
      return x0 <= x1 && x1 < COLS && y0 <= y1 && y1 < STRIPES * 8;
   endfunction

   function automatic void paint(int x, int y, bit on);
      int idx;
      idx = x + (y / 8) * COLS;
      shadow_frame[idx][y % 8] = on;
   endfunction

   function automatic void widen_damage(int y0, int y1);
      if (y0 / 8 < damage_top) damage_top = y0 / 8;
      if (y1 / 8 > damage_bottom) damage_bottom = y1 / 8;
   endfunction

   function automatic msfe_pkg::rsp_type frame_predict(msfe_pkg::req_type q);
      msfe_pkg::rsp_type r;
      int      w, h, area, span, off;
      bit      on;
      r = '0;
      case (msfe_pkg::opcode_type'(q.opcode))
         msfe_pkg::OP_FILL: begin
            if (!bounds_ok(q.x_first, q.x_last, q.y_first, q.y_last)) begin
               r.status = msfe_pkg::ST_RANGE;
            end else begin
               for (int x = q.x_first; x <= q.x_last; x++)
                  for (int y = q.y_first; y <= q.y_last; y++) paint(x, y, q.colour_flag);
               widen_damage(q.y_first, q.y_last);
            end
         end
         msfe_pkg::OP_OPEN: begin
            if (!bounds_ok(q.x_first, q.x_last, q.y_first, q.y_last)) begin
               r.status = msfe_pkg::ST_RANGE;
               window_open = 0;
               window_invert = 0;
            end else begin
               win_x0 = q.x_first; win_x1 = q.x_last;
               win_y0 = q.y_first; win_y1 = q.y_last;
               pixel_cursor = 0;
               window_open = 1;
               window_invert = q.colour_flag;
            end
         end
         msfe_pkg::OP_DATA: begin
            if (!window_open) begin
               r.status = msfe_pkg::ST_NO_RECT;
            end else begin
               w = win_x1 - win_x0 + 1;
               h = win_y1 - win_y0 + 1;
               area = w * h;
               for (int k = 0; k < 8 && pixel_cursor < area; k++) begin
                  on = q.pixel_bits[7-k] ^ window_invert;
                  paint(win_x0 + pixel_cursor % w, win_y0 + pixel_cursor / w, on);
                  pixel_cursor++;
               end
               widen_damage(win_y0, win_y1);
               if (pixel_cursor >= area) begin
                  window_open = 0;
                  window_invert = 0;
               end
            end
         end
         default: begin
            if (damage_top <= damage_bottom && damage_bottom < STRIPES) begin
               span = COLS * (damage_bottom - damage_top + 1);
               r.out_valid = 1;
               if (flush_step == 0) begin
                  r.out_byte = msfe_pkg::CMD_Y | 8'(damage_top);
                  r.out_is_command = 1;
                  flush_step = 1;
               end else if (flush_step == 1) begin
                  r.out_byte = msfe_pkg::CMD_X;
                  r.out_is_command = 1;
                  flush_step = 2;
               end else begin
                  off = flush_step - 2;
                  if (off >= span) off = span - 1;
                  r.out_byte = shadow_frame[damage_top * COLS + off];
                  if (off + 1 >= span) begin
                     r.out_last = 1;
                     flush_step = 0;
                     damage_top = STRIPES;
                     damage_bottom = 0;
                  end else begin
                     flush_step++;
                  end
               end
            end else begin
               flush_step = 0;
            end
         end
      endcase
      return r;
   endfunction

   function automatic msfe_pkg::req_type rand_req();
      bit [63:0] raw;
      raw = {$urandom, $urandom};
      return raw[$bits(msfe_pkg::req_type)-1:0];
   endfunction

   function automatic msfe_pkg::req_type make_req(msfe_pkg::opcode_type op, bit flag,
                                                  int x0, int x1, int y0, int y1, int bits);
      msfe_pkg::req_type q;
      q.opcode = op; q.colour_flag = flag;
      q.x_first = 7'(x0); q.x_last = 7'(x1);
      q.y_first = 6'(y0); q.y_last = 6'(y1);
      q.pixel_bits = 8'(bits);
      return q;
   endfunction

   function automatic msfe_pkg::req_type random_rect(msfe_pkg::opcode_type op, int max_w,
                                                     int max_h);
      msfe_pkg::req_type q;
      int      x0, y0;
      q = rand_req();
      q.opcode = op;
      if ($urandom_range(0, 9) != 0) begin
         x0 = $urandom_range(0, COLS - 1);
         y0 = $urandom_range(0, STRIPES * 8 - 1);
         q.x_first = 7'(x0);
         q.y_first = 6'(y0);
         q.x_last = 7'((x0 + $urandom_range(0, max_w - 1) < COLS) ?
                       x0 + $urandom_range(0, max_w - 1) : COLS - 1);
         q.y_last = 6'((y0 + $urandom_range(0, max_h - 1) < STRIPES * 8) ?
                       y0 + $urandom_range(0, max_h - 1) : STRIPES * 8 - 1);
      end
      return q;
   endfunction

   task automatic send_beat(msfe_pkg::req_type q, bit fixed, msfe_pkg::rsp_type fixed_rsp);
      int      gap;
      msfe_pkg::rsp_type predicted;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_data <= q;
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      predicted = frame_predict(q);
      expected_beats.push_back(fixed ? fixed_rsp : predicted);
      sent_count++;
   endtask

   task automatic add_row(msfe_pkg::req_type q, bit fixed, msfe_pkg::rsp_type r);
      table_row_type t;
      t.req = q; t.fixed = fixed; t.rsp = r;
      directed.push_back(t);
   endtask

   task automatic compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
         failed = 1;
      end
   endtask

   initial begin
      int      stall;
      msfe_pkg::rsp_type e;
      rsp_pop <= 1'b0;
      @(negedge reset);
      forever begin
         stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         if (expected_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %h", $time, rsp_data);
            failed = 1;
         end else begin
            e = expected_beats.pop_front();
            compare_field("out_byte", e.out_byte, rsp_data.out_byte);
            compare_field("out_is_command", e.out_is_command, rsp_data.out_is_command);
            compare_field("out_valid", e.out_valid, rsp_data.out_valid);
            compare_field("out_last", e.out_last, rsp_data.out_last);
            compare_field("status", e.status, rsp_data.status);
         end
      end
   end

   initial begin
      msfe_pkg::rsp_type none, ok, range_err, closed_err;
      msfe_pkg::req_type q;
      int      pick, beats, area;
      none = '0;
      ok = '0;
      range_err = '0;
      range_err.status = msfe_pkg::ST_RANGE;
      closed_err = '0;
      closed_err.status = msfe_pkg::ST_NO_RECT;
      for (int i = 0; i < COLS * STRIPES; i++) shadow_frame[i] = '0;
      damage_top = STRIPES; damage_bottom = 0;
      win_x0 = 0; win_x1 = 0; win_y0 = 0; win_y1 = 0;
      pixel_cursor = 0; flush_step = 0; window_open = 0; window_invert = 0;

      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      add_row(make_req(msfe_pkg::OP_FLUSH, 1, 127, 127, 63, 63, 255), 1, none);
      add_row(make_req(msfe_pkg::OP_DATA, 0, 0, 0, 0, 0, 255), 1, closed_err);
      add_row(make_req(msfe_pkg::OP_FILL, 1, 0, 83, 0, 47, 0), 1, ok);
      add_row(make_req(msfe_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0), 1,
              msfe_pkg::rsp_type'{8'h40, 1'b1, 1'b1, 1'b0, msfe_pkg::ST_OK});
      add_row(make_req(msfe_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0), 1,
              msfe_pkg::rsp_type'{8'h80, 1'b1, 1'b1, 1'b0, msfe_pkg::ST_OK});
      add_row(make_req(msfe_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0), 1,
              msfe_pkg::rsp_type'{8'hFF, 1'b0, 1'b1, 1'b0, msfe_pkg::ST_OK});
      add_row(make_req(msfe_pkg::OP_FILL, 1, 84, 84, 0, 0, 0), 1, range_err);
      add_row(make_req(msfe_pkg::OP_FILL, 1, 0, 0, 0, 48, 0), 1, range_err);
      add_row(make_req(msfe_pkg::OP_FILL, 0, 10, 5, 3, 3, 0), 1, range_err);
      add_row(make_req(msfe_pkg::OP_OPEN, 1, 127, 127, 63, 63, 255), 1, range_err);
      add_row(make_req(msfe_pkg::OP_OPEN, 0, 0, 0, 20, 19, 0), 1, range_err);
      add_row(make_req(msfe_pkg::OP_FILL, 0, 0, 83, 40, 47, 255), 1, ok);
      add_row(make_req(msfe_pkg::OP_OPEN, 1, 3, 5, 9, 10, 0), 1, ok);
      add_row(make_req(msfe_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'hA5), 0, none);
      add_row(make_req(msfe_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h00), 1, closed_err);
      add_row(make_req(msfe_pkg::OP_OPEN, 0, 0, 83, 47, 47, 0), 1, ok);
      add_row(make_req(msfe_pkg::OP_DATA, 1, 127, 0, 63, 0, 8'hFF), 0, none);
      add_row(make_req(msfe_pkg::OP_DATA, 0, 0, 127, 0, 63, 8'h5A), 0, none);
      add_row(make_req(msfe_pkg::OP_OPEN, 0, 0, 90, 0, 0, 0), 1, range_err);
      add_row(make_req(msfe_pkg::OP_DATA, 0, 0, 0, 0, 0, 8'h3C), 1, closed_err);
      add_row(make_req(msfe_pkg::OP_FILL, 1, 0, 0, 8, 15, 0), 1, ok);
      for (int i = 0; i < 8; i++) begin
         add_row(make_req(msfe_pkg::OP_FLUSH, 0, 0, 0, 0, 0, 0), 0, none);
      end
      foreach (directed[i]) send_beat(directed[i].req, directed[i].fixed, directed[i].rsp);

      req_push <= 1'b0;
      wait (expected_beats.size() == 0);
      @(posedge clock);

      while (sent_count < ITEM_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 5) begin
            send_beat(rand_req(), 0, none);
         end else if (pick < 28) begin
            q = random_rect(msfe_pkg::OP_FILL, $urandom_range(0, 19) == 0 ? COLS : 8,
                            $urandom_range(0, 19) == 0 ? 48 : 12);
            send_beat(q, 0, none);
         end else if (pick < 62) begin
            q = random_rect(msfe_pkg::OP_OPEN, 6, 10);
            send_beat(q, 0, none);
            area = (q.x_last - q.x_first + 1) * (q.y_last - q.y_first + 1);
            beats = bounds_ok(q.x_first, q.x_last, q.y_first, q.y_last) ? (area + 7) / 8 : 2;
            beats = beats + $urandom_range(0, 2) - ($urandom_range(0, 3) == 0 ? 1 : 0);
            for (int i = 0; i < beats; i++) begin
               q = rand_req();
               q.opcode = msfe_pkg::OP_DATA;
               send_beat(q, 0, none);
            end
         end else if (pick < 64) begin
            req_push <= 1'b0;
            wait (expected_beats.size() == 0);
            @(posedge clock);
         end else begin
            beats = $urandom_range(0, 4) == 0 ? 520 : $urandom_range(1, 100);
            for (int i = 0; i < beats && sent_count < ITEM_TARGET; i++) begin
               q = rand_req();
               q.opcode = msfe_pkg::OP_FLUSH;
               send_beat(q, 0, none);
            end
         end
      end

      req_push <= 1'b0;
      wait (expected_beats.size() == 0);
      repeat (1200) @(posedge clock);
      if (!failed && expected_beats.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
